FILE: rtl/sll_pkg.sv
// Shared types and constants for the stack language lexer.
package sll_pkg;

  localparam int unsigned MaxNestDepth = 255;
  localparam int unsigned DepthW       = $clog2(MaxNestDepth + 1);
  localparam int unsigned ValueW       = 31;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned PtrW         = $clog2(FifoDepth);
  localparam int unsigned CntW         = $clog2(FifoDepth + 1);

  localparam logic [ValueW-1:0] NumMax = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    KindInt    = 3'd0,
    KindStr    = 3'd1,
    KindLambda = 3'd2,
    KindVar    = 3'd3,
    KindChar   = 3'd4,
    KindErr    = 3'd5
  } token_kind_e;

  typedef enum logic [1:0] {
    ErrBadvar = 2'd0,
    ErrUnterm = 2'd1,
    ErrDeep   = 2'd2
  } err_code_e;

  typedef struct packed {
    token_kind_e       kind;
    logic [ValueW-1:0] value;
    logic              has_char;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic result_t mk_res(token_kind_e kind, logic [ValueW-1:0] value,
                                     logic has_char, logic last);
    result_t r;
    r.kind     = kind;
    r.value    = value;
    r.has_char = has_char;
    r.last     = last;
    return r;
  endfunction

  function automatic result_t mk_err(err_code_e code);
    return mk_res(KindErr, ValueW'(code), 1'b0, 1'b1);
  endfunction

endpackage

FILE: rtl/sll_core.sv
// Input register, lexer state and single-pass token step.
module sll_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_char_i,
  input  logic            in_eoi_i,
  input  logic            room_i,
  output sll_pkg::push_t  push_o
);
  import sll_pkg::*;

  typedef enum logic [2:0] {
    LxIdle    = 3'd0,
    LxNumber  = 3'd1,
    LxString  = 3'd2,
    LxLambda  = 3'd3,
    LxLetter  = 3'd4,
    LxQuote   = 3'd5,
    LxComment = 3'd6
  } lex_mode_e;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLbrack = 8'h5B;
  localparam logic [7:0] ChRbrack = 8'h5D;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7A;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSemi   = 8'h3B;

  logic              in_vld_q;
  logic [7:0]        char_q;
  logic              eoi_q;
  logic              proc;

  lex_mode_e         mode_q, mode_d;
  logic [ValueW-1:0] accum_q, accum_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [7:0]        letter_q, letter_d;

  lex_mode_e         st_mode;
  logic [ValueW-1:0] st_accum;
  logic [DepthW-1:0] st_depth;
  logic [7:0]        st_letter;
  logic              st_emit;
  result_t           st_res;

  logic              is_digit;
  logic [7:0]        digit;
  logic [ValueW+3:0] num_next;
  logic [ValueW-1:0] char_val;

  assign proc       = in_vld_q && room_i;
  assign in_ready_o = !in_vld_q || room_i;
  assign is_digit   = (char_q >= ChZero) && (char_q <= ChNine);
  assign digit      = char_q - ChZero;
  assign char_val   = ValueW'(char_q);
  assign num_next   = (ValueW+4)'({accum_q, 3'b000}) + (ValueW+4)'({accum_q, 1'b0})
                    + (ValueW+4)'(digit);

  always_comb begin
    st_mode   = LxIdle;
    st_accum  = '0;
    st_depth  = '0;
    st_letter = '0;
    st_emit   = 1'b0;
    st_res    = mk_res(KindChar, char_val, 1'b1, 1'b1);
    if (char_q == ChSpace || char_q == ChLf || char_q == ChTab) begin
      st_mode = LxIdle;
    end else if (is_digit) begin
      st_mode  = LxNumber;
      st_accum = ValueW'(digit);
    end else if (char_q == ChDquote) begin
      st_mode = LxString;
    end else if (char_q == ChSquote) begin
      st_mode = LxQuote;
    end else if (char_q == ChLbrack) begin
      st_mode  = LxLambda;
      st_depth = DepthW'(1);
    end else if (char_q >= ChLowA && char_q <= ChLowZ) begin
      st_mode   = LxLetter;
      st_letter = char_q;
    end else if (char_q == ChLbrace) begin
      st_mode = LxComment;
    end else begin
      st_emit = 1'b1;
    end
  end

  always_comb begin
    mode_d        = mode_q;
    accum_d       = accum_q;
    depth_d       = depth_q;
    letter_d      = letter_q;
    push_o.count  = 2'd0;
    push_o.res0   = '0;
    push_o.res1   = '0;
    if (proc) begin
      if (eoi_q) begin
        mode_d   = LxIdle;
        accum_d  = '0;
        depth_d  = '0;
        letter_d = '0;
        case (mode_q)
          LxIdle: begin
            push_o.count = 2'd0;
          end
          LxNumber: begin
            push_o.count = 2'd1;
            push_o.res0  = mk_res(KindInt, accum_q, 1'b0, 1'b1);
          end
          LxLetter: begin
            push_o.count = 2'd1;
            push_o.res0  = mk_err(ErrBadvar);
          end
          default: begin
            push_o.count = 2'd1;
            push_o.res0  = mk_err(ErrUnterm);
          end
        endcase
      end else begin
        case (mode_q)
          LxIdle: begin
            mode_d       = st_mode;
            accum_d      = st_accum;
            depth_d      = st_depth;
            letter_d     = st_letter;
            push_o.count = {1'b0, st_emit};
            push_o.res0  = st_res;
          end
          LxNumber: begin
            if (is_digit) begin
              accum_d = (num_next > (ValueW+4)'(NumMax)) ? NumMax : num_next[ValueW-1:0];
            end else begin
              mode_d       = st_mode;
              accum_d      = st_accum;
              depth_d      = st_depth;
              letter_d     = st_letter;
              push_o.res0  = mk_res(KindInt, accum_q, 1'b0, 1'b1);
              push_o.res1  = st_res;
              push_o.count = st_emit ? 2'd2 : 2'd1;
            end
          end
          LxString: begin
            push_o.count = 2'd1;
            if (char_q == ChDquote) begin
              mode_d      = LxIdle;
              push_o.res0 = mk_res(KindStr, '0, 1'b0, 1'b1);
            end else begin
              push_o.res0 = mk_res(KindStr, char_val, 1'b1, 1'b0);
            end
          end
          LxLambda: begin
            push_o.count = 2'd1;
            push_o.res0  = mk_res(KindLambda, char_val, 1'b1, 1'b0);
            if (char_q == ChLbrack) begin
              if (depth_q >= DepthW'(MaxNestDepth)) begin
                mode_d      = LxIdle;
                depth_d     = '0;
                push_o.res0 = mk_err(ErrDeep);
              end else begin
                depth_d = depth_q + DepthW'(1);
              end
            end else if (char_q == ChRbrack) begin
              if (depth_q <= DepthW'(1)) begin
                mode_d      = LxIdle;
                depth_d     = '0;
                push_o.res0 = mk_res(KindLambda, '0, 1'b0, 1'b1);
              end else begin
                depth_d = depth_q - DepthW'(1);
              end
            end
          end
          LxLetter: begin
            if (char_q == ChColon || char_q == ChSemi) begin
              mode_d       = LxIdle;
              letter_d     = '0;
              push_o.count = 2'd2;
              push_o.res0  = mk_res(KindVar, ValueW'(letter_q), 1'b1, 1'b0);
              push_o.res1  = mk_res(KindVar, char_val, 1'b1, 1'b1);
            end else begin
              mode_d       = st_mode;
              accum_d      = st_accum;
              depth_d      = st_depth;
              letter_d     = st_letter;
              push_o.res0  = mk_err(ErrBadvar);
              push_o.res1  = st_res;
              push_o.count = st_emit ? 2'd2 : 2'd1;
            end
          end
          LxQuote: begin
            mode_d       = LxIdle;
            push_o.count = 2'd1;
            push_o.res0  = mk_res(KindInt, char_val, 1'b0, 1'b1);
          end
          LxComment: begin
            if (char_q == ChRbrace) begin
              mode_d = LxIdle;
            end
          end
          default: begin
            mode_d       = st_mode;
            accum_d      = st_accum;
            depth_d      = st_depth;
            letter_d     = st_letter;
            push_o.count = {1'b0, st_emit};
            push_o.res0  = st_res;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= LxIdle;
      accum_q  <= '0;
      depth_q  <= '0;
      letter_q <= '0;
    end else begin
      mode_q   <= mode_d;
      accum_q  <= accum_d;
      depth_q  <= depth_d;
      letter_q <= letter_d;
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= in_char_i;
      eoi_q  <= in_eoi_i;
    end
  end

endmodule

FILE: rtl/sll_fifo.sv
// Result queue: takes up to two result beats per cycle, hands out one.
module sll_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sll_pkg::push_t   push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sll_pkg::result_t out_res_o
);
  import sll_pkg::*;

  result_t         mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            pop;

  assign room_o      = count_q <= CntW'(FifoDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_res_o   = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.count);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_q + CntW'(push_i.count) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.res1;
    end
  end

endmodule

FILE: rtl/stack_language_lexer.sv
// Top level of the stack language lexer.
//
// Slave channel: one beat per source byte in s_axis_tdata[7:0]; s_axis_tuser[0]
// set marks an end-of-input flush (the byte is ignored, pending token closes).
// Master channel: one beat per result. m_axis_tdata[30:0] is the value,
// m_axis_tuser[2:0] the token kind, m_axis_tuser[3] set when the value is one
// content character, m_axis_tlast marks the final beat of a token.
// A byte causes zero, one or two result beats.
// Results of an accepted byte pass the input register and then the result
// queue before they are offered. Throughput: one byte per cycle while the
// queue has room; a byte that gives two results puts two beats into the
// four-entry result queue, which absorbs them. The input register advances
// while the queue has room for two beats, so s_axis_tready drops only while a
// byte is held and the queue holds more than two beats.
// Reset clears the lexer to idle and empties the queue; no beat is offered
// until a byte producing results arrives.
module stack_language_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic [0:0]  s_axis_tuser,   // [0] end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] value, [31] zero
  output logic [3:0]  m_axis_tuser,   // [2:0] token_kind, [3] has_char
  output logic        m_axis_tlast
);
  import sll_pkg::*;

  push_t   push;
  logic    room;
  result_t out_res;

  sll_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .in_eoi_i   (s_axis_tuser[0]),
    .room_i     (room),
    .push_o     (push)
  );

  sll_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.value};
  assign m_axis_tuser = {out_res.has_char, out_res.kind};
  assign m_axis_tlast = out_res.last;

endmodule

FILE: rtl/sll_checker.sv
// Port-level assertions for the stack language lexer, bound to the top level.
module sll_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import sll_pkg::*;

  logic [2:0] kind;
  assign kind = m_axis_tuser[2:0];

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
      |=> $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  a_no_char_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tlast)
    else $error("beat without content character not marked last");

  a_single_beat_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind == KindInt || kind == KindErr || kind == KindChar)
      |-> m_axis_tlast)
    else $error("single-beat token not marked last");

  a_var_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && kind == KindVar && !m_axis_tlast
      |=> m_axis_tvalid && m_axis_tuser[2:0] == KindVar && m_axis_tlast)
    else $error("variable letter not followed by its suffix beat");

endmodule

bind stack_language_lexer sll_checker u_sll_checker (.*);
